// ===== src/deer_pkg.sv =====
// ----------------------------------------------------------------------------
// deer_pkg
// Shared types and codes for the duplicate-filtering expiring event ring.
// ----------------------------------------------------------------------------
package deer_pkg;

  localparam int DEER_DEPTH = 16;

  localparam int SRC_W  = 8;
  localparam int SEQ_W  = 16;
  localparam int STR_W  = 16;
  localparam int TIME_W = 32;
  localparam int EXP_W  = 16;
  localparam int STAT_W = 2;
  localparam int OUT_CNT_W = 5;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  typedef enum logic {
    CMD_ARRIVAL = 1'b0,
    CMD_SWEEP   = 1'b1
  } deer_cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_STORED = 2'd0,
    STAT_DUP    = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_SWEEP  = 2'd3
  } deer_status_e;

  typedef enum logic {
    REG_EXPIRY = 1'b0,
    REG_NONE   = 1'b1
  } deer_reg_e;

  localparam logic [EXP_W-1:0] EXPIRY_RESET = 16'd1000;

  typedef struct packed {
    logic [SRC_W-1:0]  source;
    logic [SEQ_W-1:0]  seq;
    logic [STR_W-1:0]  strength;
    logic [TIME_W-1:0] stamp;
  } deer_entry_t;

  typedef struct packed {
    logic [SRC_W-1:0]  source;
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] now;
    logic [EXP_W-1:0]  expiry;
  } deer_key_t;

  typedef struct packed {
    logic match;
    logic expired;
  } deer_cmp_t;

endpackage

// ===== src/dedup_expiring_event_ring.sv =====
// ----------------------------------------------------------------------------
// dedup_expiring_event_ring
// Ring of timestamped events with duplicate filter and expiry sweep.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. An arrival that is not a duplicate is
// compared with every occupied entry, one entry compared per cycle, and then
// inserted; a duplicate ends the walk at the matching entry, and an arrival on
// an empty ring goes straight to the insert. A sweep removes expired entries
// from head and stops at an unexpired entry or when the ring is empty; a sweep
// on an empty ring goes straight to the result. s_axis_tready returns in the
// same cycle that m_axis_tvalid rises, as the result is loaded, and a result
// held by m_axis_tready stalls the next one. The walk uses the single read
// port of the entry memory, which the sequencer steps from head one entry per
// cycle through one shared compare unit. Entries need no clearing after
// reset: only occupied entries are ever compared. Status values: 0 stored,
// 1 duplicate, 2 ring full, 3 sweep done.
// ----------------------------------------------------------------------------
module dedup_expiring_event_ring #(
  parameter int RING_DEPTH = deer_pkg::DEER_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // s_axis_tdata: source_id[7:0], seq_count[23:8], strength[39:24], now_ms[71:40]
  input  logic [71:0]                   s_axis_tdata,
  // s_axis_tuser: cmd[0]
  input  logic [0:0]                    s_axis_tuser,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // m_axis_tdata: occupancy[4:0], removed[9:5], zero[15:10]
  output logic [15:0]                   m_axis_tdata,
  // m_axis_tuser: status[1:0]
  output logic [deer_pkg::STAT_W-1:0]   m_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [deer_pkg::APB_AW-1:0]   paddr,
  input  logic [deer_pkg::APB_DW-1:0]   pwdata,
  output logic [deer_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import deer_pkg::*;

  localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int SUM_W = IDX_W + 1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_FETCH  = 5'b00010,
    ST_WALK   = 5'b00100,
    ST_INSERT = 5'b01000,
    ST_DONE   = 5'b10000
  } deer_state_e;

  deer_state_e state_q, state_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  deer_cmd_e        cmd_q, cmd_d;
  deer_status_e     status_q, status_d;
  logic [EXP_W-1:0] expiry_q, expiry_d;

  deer_entry_t item_q, item_d;

  logic                m_valid_q, m_valid_d;
  deer_status_e        m_status_q, m_status_d;
  logic [OUT_CNT_W-1:0] m_occ_q, m_occ_d;
  logic [OUT_CNT_W-1:0] m_rem_q, m_rem_d;

  deer_entry_t mem [RING_DEPTH];
  deer_entry_t rdata_q;
  logic        mem_we;
  logic [IDX_W-1:0] tail_idx;
  logic [SUM_W-1:0] tail_sum;

  deer_key_t key;
  deer_cmp_t cmp;

  logic s_hs;
  logic cfg_we;
  deer_reg_e cfg_sel;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    next_idx = (idx == IDX_W'(RING_DEPTH - 1)) ? '0 : idx + IDX_W'(1);
  endfunction

  // APB register
  assign pready  = 1'b1;
  assign cfg_sel = deer_reg_e'(paddr[2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_comb begin
    expiry_d = expiry_q;
    if (cfg_we && cfg_sel == REG_EXPIRY) begin
      expiry_d = pwdata[EXP_W-1:0];
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_EXPIRY: prdata = {{(APB_DW-EXP_W){1'b0}}, expiry_q};
      default:    prdata = '0;
    endcase
  end

  // entry memory
  assign tail_sum = SUM_W'(head_q) + SUM_W'(fill_q);
  assign tail_idx = (tail_sum >= SUM_W'(RING_DEPTH)) ? IDX_W'(tail_sum - SUM_W'(RING_DEPTH))
                                                     : IDX_W'(tail_sum);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[tail_idx] <= item_q;
    end
    rdata_q <= mem[ptr_q];
  end

  // compare unit
  assign key.source = item_q.source;
  assign key.seq    = item_q.seq;
  assign key.now    = item_q.stamp;
  assign key.expiry = expiry_q;

  deer_cmp u_cmp (
    .entry_i (rdata_q),
    .key_i   (key),
    .res_o   (cmp)
  );

  // sequencer
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_hs          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    fill_d     = fill_q;
    ptr_d      = ptr_q;
    cnt_d      = cnt_q;
    cmd_d      = cmd_q;
    status_d   = status_q;
    item_d     = item_q;
    mem_we     = 1'b0;
    m_valid_d  = m_valid_q;
    m_status_d = m_status_q;
    m_occ_d    = m_occ_q;
    m_rem_d    = m_rem_q;

    if (m_axis_tvalid && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_hs) begin
          cmd_d           = deer_cmd_e'(s_axis_tuser[0]);
          item_d.source   = s_axis_tdata[7:0];
          item_d.seq      = s_axis_tdata[23:8];
          item_d.strength = s_axis_tdata[39:24];
          item_d.stamp    = s_axis_tdata[71:40];
          ptr_d           = head_q;
          cnt_d           = '0;
          status_d        = STAT_SWEEP;
          if (fill_q != '0) begin
            state_d = ST_FETCH;
          end else if (deer_cmd_e'(s_axis_tuser[0]) == CMD_ARRIVAL) begin
            state_d = ST_INSERT;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_FETCH: begin
        ptr_d   = next_idx(ptr_q);
        state_d = ST_WALK;
      end
      ST_WALK: begin
        ptr_d = next_idx(ptr_q);
        if (cmd_q == CMD_ARRIVAL) begin
          if (cmp.match) begin
            status_d = STAT_DUP;
            state_d  = ST_DONE;
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
            if (cnt_q + CNT_W'(1) == fill_q) begin
              state_d = ST_INSERT;
            end
          end
        end else begin
          status_d = STAT_SWEEP;
          if (cmp.expired) begin
            head_d = next_idx(head_q);
            fill_d = fill_q - CNT_W'(1);
            cnt_d  = cnt_q + CNT_W'(1);
            if (fill_q == CNT_W'(1)) begin
              state_d = ST_DONE;
            end
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_INSERT: begin
        if (fill_q == CNT_W'(RING_DEPTH)) begin
          status_d = STAT_FULL;
        end else begin
          mem_we   = 1'b1;
          fill_d   = fill_q + CNT_W'(1);
          status_d = STAT_STORED;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          m_status_d = status_q;
          m_occ_d    = OUT_CNT_W'(fill_q);
          m_rem_d    = (cmd_q == CMD_SWEEP) ? OUT_CNT_W'(cnt_q) : '0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      fill_q    <= '0;
      ptr_q     <= '0;
      cnt_q     <= '0;
      cmd_q     <= CMD_ARRIVAL;
      status_q  <= STAT_STORED;
      expiry_q  <= EXPIRY_RESET;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      fill_q    <= fill_d;
      ptr_q     <= ptr_d;
      cnt_q     <= cnt_d;
      cmd_q     <= cmd_d;
      status_q  <= status_d;
      expiry_q  <= expiry_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    m_status_q <= m_status_d;
    m_occ_q    <= m_occ_d;
    m_rem_q    <= m_rem_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {6'b0, m_rem_q, m_occ_q};

  // assertions
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(RING_DEPTH))
    else $error("fill count above ring depth");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_hs |=> !s_axis_tready)
    else $error("ready while a transaction is in progress");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
    else $error("result raised outside the done state");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INSERT && fill_q != CNT_W'(RING_DEPTH)) |=>
      fill_q == $past(fill_q) + CNT_W'(1))
    else $error("insert did not grow the ring");

  a_head_moves_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_WALK) |=> $stable(head_q))
    else $error("head moved outside a sweep walk");

endmodule

// ===== src/deer_cmp.sv =====
// ----------------------------------------------------------------------------
// deer_cmp
// Shared entry compare unit: duplicate match and wrapping age check.
// ----------------------------------------------------------------------------
module deer_cmp (
  input  deer_pkg::deer_entry_t entry_i,
  input  deer_pkg::deer_key_t   key_i,
  output deer_pkg::deer_cmp_t   res_o
);
  import deer_pkg::*;

  logic [TIME_W-1:0] age;

  assign age           = key_i.now - entry_i.stamp;
  assign res_o.match   = (entry_i.seq == key_i.seq) && (entry_i.source == key_i.source);
  assign res_o.expired = age > {{(TIME_W-EXP_W){1'b0}}, key_i.expiry};

endmodule

// ===== bench/dedup_expiring_event_ring_chk.sv =====
// ----------------------------------------------------------------------------
// dedup_expiring_event_ring_chk
// Scoreboard for the duplicate-filtering expiring event ring. It watches the
// input stream, the result stream and the register port, keeps its own copy
// of the ring and the expiry setting, predicts one outcome per accepted
// transaction and compares each accepted result, field by field, with the
// oldest prediction.
// ----------------------------------------------------------------------------
module dedup_expiring_event_ring_chk (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [71:0]                   s_axis_tdata,
  input  logic [0:0]                    s_axis_tuser,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [15:0]                   m_axis_tdata,
  input  logic [deer_pkg::STAT_W-1:0]   m_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [deer_pkg::APB_AW-1:0]   paddr,
  input  logic [deer_pkg::APB_DW-1:0]   pwdata,
  input  logic [deer_pkg::APB_DW-1:0]   prdata,
  input  logic                          pready,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import deer_pkg::*;

  localparam logic [APB_AW-1:0] ADDR_EXPIRY = {REG_EXPIRY, 2'b00};

  typedef struct packed {
    deer_status_e         status;
    logic [OUT_CNT_W-1:0] occupancy;
    logic [OUT_CNT_W-1:0] removed;
  } ring_outcome_t;

  logic [SRC_W-1:0]  held_source   [DEER_DEPTH];
  logic [SEQ_W-1:0]  held_seq      [DEER_DEPTH];
  logic [STR_W-1:0]  held_strength [DEER_DEPTH];
  logic [TIME_W-1:0] held_stamp    [DEER_DEPTH];
  int                head_slot;
  int                held_count;
  logic [EXP_W-1:0]  expiry_ms;
  ring_outcome_t     pending_outcomes [$];

  function automatic ring_outcome_t next_ring_outcome(
    deer_cmd_e         cmd,
    logic [SRC_W-1:0]  src,
    logic [SEQ_W-1:0]  seq,
    logic [STR_W-1:0]  str,
    logic [TIME_W-1:0] now
  );
    ring_outcome_t     res;
    logic              seen;
    int                slot;
    logic [TIME_W-1:0] age;
    seen = 1'b0;
    res.removed = '0;
    if (cmd == CMD_ARRIVAL) begin
      for (int k = 0; k < held_count; k++) begin
        slot = (head_slot + k) % DEER_DEPTH;
        if (held_seq[slot] == seq && held_source[slot] == src) seen = 1'b1;
      end
      if (seen) begin
        res.status = STAT_DUP;
      end else if (held_count >= DEER_DEPTH) begin
        res.status = STAT_FULL;
      end else begin
        slot = (head_slot + held_count) % DEER_DEPTH;
        held_source[slot]   = src;
        held_seq[slot]      = seq;
        held_strength[slot] = str;
        held_stamp[slot]    = now;
        held_count++;
        res.status = STAT_STORED;
      end
    end else begin
      age = now - held_stamp[head_slot];
      while (held_count > 0 && age > expiry_ms) begin
        head_slot = (head_slot + 1) % DEER_DEPTH;
        held_count--;
        res.removed = res.removed + 1'b1;
        age = now - held_stamp[head_slot];
      end
      res.status = STAT_SWEEP;
    end
    res.occupancy = OUT_CNT_W'(held_count);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    ring_outcome_t want;
    ring_outcome_t got;
    if (!rst_ni) begin
      head_slot  = 0;
      held_count = 0;
      expiry_ms  = EXPIRY_RESET;
      pending_outcomes.delete();
      fail_count = 0;
      pending    = 0;
    end else begin
      if (psel && penable && pready && paddr == ADDR_EXPIRY) begin
        if (pwrite) begin
          expiry_ms = pwdata[EXP_W-1:0];
        end else if (prdata !== APB_DW'(expiry_ms)) begin
          $error("expiry_ms readback expected %0d got %0d", expiry_ms, prdata);
          fail_count++;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.status    = deer_status_e'(m_axis_tuser);
        got.occupancy = m_axis_tdata[4:0];
        got.removed   = m_axis_tdata[9:5];
        if (pending_outcomes.size() == 0) begin
          $error("result with nothing expected: status %0d occupancy %0d removed %0d",
                 got.status, got.occupancy, got.removed);
          fail_count++;
        end else begin
          want = pending_outcomes.pop_front();
          if (got.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.occupancy !== want.occupancy) begin
            $error("occupancy expected %0d got %0d", want.occupancy, got.occupancy);
            fail_count++;
          end
          if (got.removed !== want.removed) begin
            $error("removed expected %0d got %0d", want.removed, got.removed);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_outcomes.push_back(next_ring_outcome(deer_cmd_e'(s_axis_tuser[0]),
                                                     s_axis_tdata[7:0],
                                                     s_axis_tdata[23:8],
                                                     s_axis_tdata[39:24],
                                                     s_axis_tdata[71:40]));
      end
      pending = pending_outcomes.size();
    end
  end

endmodule

// ===== bench/dedup_expiring_event_ring_tb.sv =====
// ----------------------------------------------------------------------------
// dedup_expiring_event_ring_tb
// Stimulus and verdict for the duplicate-filtering expiring event ring. A
// directed pass covers empty sweeps, duplicates, field extremes, a full ring,
// wrapping time stamps and the expiry extremes; random phases at several
// expiry settings mix arrivals, resent events and sweeps, all but one under
// random stalls on both streams. The checker instance does all the comparing.
// ----------------------------------------------------------------------------
module dedup_expiring_event_ring_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import deer_pkg::*;

  localparam logic [APB_AW-1:0] ADDR_EXPIRY = {REG_EXPIRY, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_SPARE  = {REG_NONE, 2'b00};

  logic                 clk_i;
  logic                 rst_ni;
  logic [71:0]          s_axis_tdata;
  logic [0:0]           s_axis_tuser;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [15:0]          m_axis_tdata;
  logic [STAT_W-1:0]    m_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [APB_AW-1:0]    paddr;
  logic [APB_DW-1:0]    pwdata;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;
  int                   fail_count;
  int                   pending;
  bit                   calm;

  dedup_expiring_event_ring uut (.*);

  dedup_expiring_event_ring_chk chk (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 34);
  endfunction

  always @(posedge clk_i) m_axis_tready <= !idle_now();

  task automatic send_event(deer_cmd_e cmd, logic [SRC_W-1:0] src, logic [SEQ_W-1:0] seq,
                            logic [STR_W-1:0] str, logic [TIME_W-1:0] now);
    if (idle_now()) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while (idle_now());
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {now, str, seq, src};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (32) @(posedge clk_i);
  endtask

  task automatic apb_access(logic wr, logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_expiry(logic [EXP_W-1:0] value);
    settle();
    apb_access(1'b1, ADDR_EXPIRY, APB_DW'(value));
    apb_access(1'b0, ADDR_EXPIRY, '0);
  endtask

  task automatic random_phase(logic [EXP_W-1:0] expiry, int count);
    logic [TIME_W-1:0] clock_ms;
    logic [SRC_W-1:0]  src;
    logic [SEQ_W-1:0]  seq;
    logic [SEQ_W-1:0]  next_seq;
    logic [SRC_W-1:0]  recent_src [8];
    logic [SEQ_W-1:0]  recent_seq [8];
    int                n_recent;
    int                roll;
    int                pick;
    set_expiry(expiry);
    clock_ms = $urandom;
    next_seq = 16'($urandom);
    n_recent = 0;
    repeat (count) begin
      if ($urandom_range(99) < 4) clock_ms = $urandom;
      else clock_ms = clock_ms + $urandom_range(expiry / 16 + 1);
      roll = $urandom_range(99);
      if (roll < 22) begin
        send_event(CMD_SWEEP, 8'($urandom), 16'($urandom), 16'($urandom), clock_ms);
      end else begin
        if (roll < 45 && n_recent > 0) begin
          pick = $urandom_range(((n_recent < 8) ? n_recent : 8) - 1);
          src  = recent_src[pick];
          seq  = recent_seq[pick];
        end else if (roll < 60) begin
          src = 8'($urandom);
          seq = 16'($urandom);
        end else begin
          src      = 8'($urandom_range(7));
          seq      = next_seq;
          next_seq = next_seq + 1'b1;
        end
        recent_src[n_recent % 8] = src;
        recent_seq[n_recent % 8] = seq;
        n_recent++;
        send_event(CMD_ARRIVAL, src, seq, 16'($urandom), clock_ms);
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    calm          = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    apb_access(1'b0, ADDR_EXPIRY, '0);

    send_event(CMD_SWEEP, 8'h00, 16'h0000, 16'h0000, 32'h0000_0000);
    send_event(CMD_ARRIVAL, 8'h00, 16'h0000, 16'h0000, 32'h0000_0000);
    send_event(CMD_ARRIVAL, 8'h00, 16'h0000, 16'h0001, 32'd5);
    send_event(CMD_ARRIVAL, 8'h01, 16'h0000, 16'h0180, 32'h0000_0000);
    send_event(CMD_ARRIVAL, 8'h00, 16'h0001, 16'h8000, 32'h0000_0000);
    send_event(CMD_ARRIVAL, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    for (int k = 0; k < 12; k++) begin
      send_event(CMD_ARRIVAL, 8'(16 + k), 16'(100 + k), 16'($urandom), 32'h0000_0000);
    end
    send_event(CMD_ARRIVAL, 8'h07, 16'h0007, 16'h0100, 32'h0000_0000);
    send_event(CMD_ARRIVAL, 8'hFF, 16'hFFFF, 16'h0000, 32'h0000_0000);
    send_event(CMD_SWEEP, 8'hFF, 16'hFFFF, 16'hFFFF, 32'd1000);
    send_event(CMD_SWEEP, 8'h00, 16'h0000, 16'h0000, 32'd1001);

    settle();
    apb_access(1'b1, ADDR_SPARE, $urandom);
    apb_access(1'b0, ADDR_EXPIRY, '0);

    set_expiry(16'h0000);
    send_event(CMD_ARRIVAL, 8'h02, 16'h0002, 16'h0200, 32'd50);
    send_event(CMD_SWEEP, 8'h00, 16'h0000, 16'h0000, 32'd50);
    send_event(CMD_SWEEP, 8'h00, 16'h0000, 16'h0000, 32'd51);

    set_expiry(16'hFFFF);
    send_event(CMD_ARRIVAL, 8'h03, 16'h0003, 16'h0300, 32'h0000_0000);
    send_event(CMD_SWEEP, 8'h00, 16'h0000, 16'h0000, 32'h0000_FFFF);
    send_event(CMD_SWEEP, 8'h00, 16'h0000, 16'h0000, 32'h0001_0000);

    random_phase(16'($urandom_range(20)), 160);
    calm = 1'b1;
    random_phase(EXPIRY_RESET, 160);
    calm = 1'b0;
    random_phase(16'($urandom), 160);
    random_phase(16'hFFFF, 170);

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
